[rtl/core/pia_pkg.sv]
// ----------------------------------------------------------------------------
// pia_pkg
// Shared constants and types of the primitive index assembler.
// ----------------------------------------------------------------------------
package pia_pkg;

	localparam int MAX_VERTICES = 65536;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int STRIDE_W     = 4;
	localparam int PROD_W       = IDX_W + STRIDE_W;
	localparam int OFS_W        = 20;
	localparam int KIND_W       = 3;
	localparam int REG_IDX_W    = 2;
	localparam int QDEPTH       = 4;
	localparam int QPTR_W       = $clog2(QDEPTH);

	localparam logic [KIND_W-1:0] KIND_TRI_LIST   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_TRI_STRIP  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TRI_FAN    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_QUADS      = 3'd3;
	localparam logic [KIND_W-1:0] KIND_QUAD_STRIP = 3'd4;

	localparam logic [REG_IDX_W-1:0] REG_PRIMITIVE_KIND = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_USE_NORMALS    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_USE_TEXTURES   = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_USE_COLORS     = 2'd3;

	localparam logic [STRIDE_W-1:0] STRIDE_BASE    = 4'd3;
	localparam logic [STRIDE_W-1:0] STRIDE_NORMALS = 4'd3;
	localparam logic [STRIDE_W-1:0] STRIDE_TEXTURE = 4'd2;
	localparam logic [STRIDE_W-1:0] STRIDE_COLORS  = 4'd4;

	// One queued job: a triangle, or the first triangle of a quad pair.
	typedef struct packed {
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic [IDX_W-1:0] c;
		logic             pair;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[rtl/core/pia_front.sv]
// ----------------------------------------------------------------------------
// pia_front
// Counts vertices of the current list and classifies each into a triangle job.
// ----------------------------------------------------------------------------
module pia_front import pia_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              list_start,
	input  logic [KIND_W-1:0] kind,
	input  q_status_t         q_st,
	output logic              wr_en,
	output job_t              wr_job
);

	localparam logic [1:0] PHASE_LAST = 2'd2;

	logic [CNT_W-1:0] count_q;
	logic [1:0]       phase_q;
	logic [CNT_W-1:0] n_base;
	logic [1:0]       phase;
	logic [IDX_W-1:0] n;
	logic             in_range;
	logic             accept;
	logic             has_job;

	always_comb begin
		n_base   = list_start ? '0 : count_q;
		phase    = list_start ? '0 : phase_q;
		n        = n_base[IDX_W-1:0];
		in_range = n_base < CNT_W'(MAX_VERTICES);
		has_job  = 1'b0;
		wr_job   = '0;
		unique case (kind)
			KIND_TRI_LIST: begin
				has_job = (phase == PHASE_LAST);
				wr_job  = '{a: n - IDX_W'(2), b: n - IDX_W'(1), c: n, pair: 1'b0};
			end
			KIND_TRI_STRIP: begin
				has_job = (n_base >= CNT_W'(2));
				if (n[0]) begin
					wr_job = '{a: n - IDX_W'(1), b: n - IDX_W'(2), c: n, pair: 1'b0};
				end else begin
					wr_job = '{a: n - IDX_W'(2), b: n - IDX_W'(1), c: n, pair: 1'b0};
				end
			end
			KIND_TRI_FAN: begin
				has_job = (n_base >= CNT_W'(2));
				wr_job  = '{a: '0, b: n - IDX_W'(1), c: n, pair: 1'b0};
			end
			KIND_QUADS: begin
				has_job = (n[1:0] == 2'b11);
				wr_job  = '{a: n - IDX_W'(3), b: n - IDX_W'(2), c: n - IDX_W'(1),
					pair: 1'b1};
			end
			KIND_QUAD_STRIP: begin
				has_job = (n_base >= CNT_W'(3)) && n[0];
				wr_job  = '{a: n - IDX_W'(3), b: n - IDX_W'(2), c: n - IDX_W'(1),
					pair: 1'b1};
			end
			default: begin
				has_job = 1'b0;
			end
		endcase
	end

	assign accept = push && !q_st.full;
	assign wr_en  = accept && in_range && has_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= '0;
		end else if (accept && in_range) begin
			count_q <= CNT_W'(n_base + CNT_W'(1));
			phase_q <= (phase == PHASE_LAST) ? 2'd0 : phase + 2'd1;
		end
	end

endmodule

[rtl/core/pia_queue.sv]
// ----------------------------------------------------------------------------
// pia_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module pia_queue import pia_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  job_t      wr_job,
	input  logic      rd_en,
	output job_t      rd_job,
	output q_status_t q_st
);

	job_t              mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign q_st.full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign q_st.empty = (cnt_q == '0);
	assign rd_job     = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			priority if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

[rtl/core/pia_back.sv]
// ----------------------------------------------------------------------------
// pia_back
// Expands jobs into triangles, scales corners by the stride, holds the result.
// ----------------------------------------------------------------------------
module pia_back import pia_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  job_t                rd_job,
	input  q_status_t           q_st,
	input  logic [STRIDE_W-1:0] stride,
	input  logic                pop,
	output logic                rd_en,
	output logic                empty,
	output logic [OFS_W-1:0]    corner_a,
	output logic [OFS_W-1:0]    corner_b,
	output logic [OFS_W-1:0]    corner_c,
	output logic                run_last
);

	logic              half_q;
	logic              out_valid_q;
	logic [OFS_W-1:0]  a_q;
	logic [OFS_W-1:0]  b_q;
	logic [OFS_W-1:0]  c_q;
	logic              last_q;
	logic              load;
	logic              first_of_pair;
	logic [IDX_W-1:0]  ia;
	logic [IDX_W-1:0]  ib;
	logic [IDX_W-1:0]  ic;
	logic [PROD_W-1:0] pa;
	logic [PROD_W-1:0] pb;
	logic [PROD_W-1:0] pc;

	assign load          = !q_st.empty && (!out_valid_q || pop);
	assign first_of_pair = rd_job.pair && !half_q;
	assign rd_en         = load && !first_of_pair;

	always_comb begin
		if (half_q) begin
			ia = rd_job.c;
			ib = rd_job.b;
			ic = rd_job.c + IDX_W'(1);
		end else begin
			ia = rd_job.a;
			ib = rd_job.b;
			ic = rd_job.c;
		end
		pa = PROD_W'(ia) * PROD_W'(stride);
		pb = PROD_W'(ib) * PROD_W'(stride);
		pc = PROD_W'(ic) * PROD_W'(stride);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				half_q      <= first_of_pair;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			a_q    <= OFS_W'(pa);
			b_q    <= OFS_W'(pb);
			c_q    <= OFS_W'(pc);
			last_q <= !first_of_pair;
		end
	end

	assign empty    = !out_valid_q;
	assign corner_a = a_q;
	assign corner_b = b_q;
	assign corner_c = c_q;
	assign run_last = last_q;

endmodule

[rtl/core/primitive_index_assembler_core.sv]
// ----------------------------------------------------------------------------
// primitive_index_assembler_core
// Turns a vertex stream into triangle corner offsets for list, strip, fan,
// quad and quad strip primitives.
//
//   channel  direction  handshake              payload
//   input    in         push / full            list_start
//   result   out        empty / pop            corner_a, corner_b, corner_c, run_last
//   config   in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One vertex is accepted every cycle while the four-entry job queue has room.
// Each result leaves through a single result register, one triangle a cycle while
// the reader pops, so quad kinds produce two triangles per completing vertex.
// An accepted vertex's result passes through the job queue, then the result register.
// Reset clears the vertex count and sets the stride to three elements.
// ----------------------------------------------------------------------------
module primitive_index_assembler_core import pia_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 list_start,
	output logic                 empty,
	input  logic                 pop,
	output logic [OFS_W-1:0]     corner_a,
	output logic [OFS_W-1:0]     corner_b,
	output logic [OFS_W-1:0]     corner_c,
	output logic                 run_last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [KIND_W-1:0]    cfg_data
);

	logic [KIND_W-1:0]   kind_q;
	logic                normals_q;
	logic                textures_q;
	logic                colors_q;
	logic [STRIDE_W-1:0] stride;
	logic                q_wr;
	logic                q_rd;
	job_t                q_wr_job;
	job_t                q_rd_job;
	q_status_t           q_st;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q     <= KIND_TRI_LIST;
			normals_q  <= 1'b0;
			textures_q <= 1'b0;
			colors_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PRIMITIVE_KIND: kind_q     <= cfg_data;
				REG_USE_NORMALS:    normals_q  <= cfg_data[0];
				REG_USE_TEXTURES:   textures_q <= cfg_data[0];
				REG_USE_COLORS:     colors_q   <= cfg_data[0];
				default:            kind_q     <= kind_q;
			endcase
		end
	end

	assign stride = STRIDE_BASE
		+ (normals_q  ? STRIDE_NORMALS : '0)
		+ (textures_q ? STRIDE_TEXTURE : '0)
		+ (colors_q   ? STRIDE_COLORS  : '0);

	assign full = q_st.full;

	pia_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.list_start (list_start),
		.kind       (kind_q),
		.q_st       (q_st),
		.wr_en      (q_wr),
		.wr_job     (q_wr_job)
	);

	pia_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_wr),
		.wr_job (q_wr_job),
		.rd_en  (q_rd),
		.rd_job (q_rd_job),
		.q_st   (q_st)
	);

	pia_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_job   (q_rd_job),
		.q_st     (q_st),
		.stride   (stride),
		.pop      (pop),
		.rd_en    (q_rd),
		.empty    (empty),
		.corner_a (corner_a),
		.corner_b (corner_b),
		.corner_c (corner_c),
		.run_last (run_last)
	);

`ifndef SYNTH
	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_st.full && q_st.empty))
		else $error("job queue reports full and empty together");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !run_last) |=> (!empty && run_last))
		else $error("second triangle of a quad did not follow the first");

	a_no_read_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> !q_st.empty)
		else $error("job read from empty queue");
`endif

endmodule

[tb/primitive_index_assembler_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// primitive_index_assembler_core_tb
// Self-checking bench for the primitive index assembler. Vertices are pushed
// under random gaps and lists, registers are rewritten between phases, and
// every triangle popped is compared against a predictor of the corner offsets
// kept in a small scoreboard class.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic [pia_pkg::OFS_W-1:0] a;
	logic [pia_pkg::OFS_W-1:0] b;
	logic [pia_pkg::OFS_W-1:0] c;
	logic                      last;
} tri_offsets_t;

class corner_predictor;
	logic [pia_pkg::KIND_W-1:0] kind;
	bit                         normals;
	bit                         textures;
	bit                         colors;
	int unsigned                vertex_idx;
	tri_offsets_t               pending_tris[$];
	int                         mismatches;

	function new();
		kind       = pia_pkg::KIND_TRI_LIST;
		normals    = 1'b0;
		textures   = 1'b0;
		colors     = 1'b0;
		vertex_idx = 0;
		mismatches = 0;
	endfunction

	function void write_reg(logic [pia_pkg::REG_IDX_W-1:0] idx,
			logic [pia_pkg::KIND_W-1:0] val);
		case (idx)
			pia_pkg::REG_PRIMITIVE_KIND: kind = val;
			pia_pkg::REG_USE_NORMALS:    normals = val[0];
			pia_pkg::REG_USE_TEXTURES:   textures = val[0];
			pia_pkg::REG_USE_COLORS:     colors = val[0];
			default: ;
		endcase
	endfunction

	function void add_tri(int unsigned a, int unsigned b, int unsigned c, bit last);
		int unsigned  stride;
		int unsigned  pa;
		int unsigned  pb;
		int unsigned  pc;
		tri_offsets_t t;
		stride = pia_pkg::STRIDE_BASE;
		if (normals) stride += pia_pkg::STRIDE_NORMALS;
		if (textures) stride += pia_pkg::STRIDE_TEXTURE;
		if (colors) stride += pia_pkg::STRIDE_COLORS;
		pa     = a * stride;
		pb     = b * stride;
		pc     = c * stride;
		t.a    = pa[pia_pkg::OFS_W-1:0];
		t.b    = pb[pia_pkg::OFS_W-1:0];
		t.c    = pc[pia_pkg::OFS_W-1:0];
		t.last = last;
		pending_tris.push_back(t);
	endfunction

	function void note_vertex(logic list_start);
		int unsigned n;
		if (list_start) vertex_idx = 0;
		if (vertex_idx >= pia_pkg::MAX_VERTICES) return;
		n = vertex_idx;
		vertex_idx = n + 1;
		case (kind)
			pia_pkg::KIND_TRI_LIST: begin
				if (n % 3 == 2) add_tri(n - 2, n - 1, n, 1'b1);
			end
			pia_pkg::KIND_TRI_STRIP: begin
				if (n >= 2) begin
					if (((n - 2) & 1) == 0) add_tri(n - 2, n - 1, n, 1'b1);
					else add_tri(n - 1, n - 2, n, 1'b1);
				end
			end
			pia_pkg::KIND_TRI_FAN: begin
				if (n >= 2) add_tri(0, n - 1, n, 1'b1);
			end
			pia_pkg::KIND_QUADS: begin
				if ((n & 3) == 3) begin
					add_tri(n - 3, n - 2, n - 1, 1'b0);
					add_tri(n - 1, n - 2, n, 1'b1);
				end
			end
			pia_pkg::KIND_QUAD_STRIP: begin
				if (n >= 3 && (n & 1) == 1) begin
					add_tri(n - 3, n - 2, n - 1, 1'b0);
					add_tri(n - 1, n - 2, n, 1'b1);
				end
			end
			default: ;
		endcase
	endfunction

	function void check_triangle(tri_offsets_t got);
		tri_offsets_t want;
		if (pending_tris.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected item a=%0d b=%0d c=%0d last=%0b",
					$time, got.a, got.b, got.c, got.last);
			return;
		end
		want = pending_tris.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: mismatch exp a=%0d b=%0d c=%0d last=%0b, got a=%0d b=%0d c=%0d last=%0b",
					$time, want.a, want.b, want.c, want.last,
					got.a, got.b, got.c, got.last);
		end
	endfunction
endclass

module primitive_index_assembler_core_tb;
	import pia_pkg::*;

	localparam int                SETTLE_CYCLES = 8;
	localparam int                RANDOM_ITEMS  = 1300;
	localparam logic [KIND_W-1:0] KIND_NONE     = 3'd5;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic                 list_start;
	logic                 empty;
	logic                 pop;
	logic [OFS_W-1:0]     corner_a;
	logic [OFS_W-1:0]     corner_b;
	logic [OFS_W-1:0]     corner_c;
	logic                 run_last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [KIND_W-1:0]    cfg_data;

	bit sender_gaps;
	bit reader_gaps;

	corner_predictor model = new();

	primitive_index_assembler_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.list_start (list_start),
		.empty      (empty),
		.pop        (pop),
		.corner_a   (corner_a),
		.corner_b   (corner_b),
		.corner_c   (corner_c),
		.run_last   (run_last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("primitive_index_assembler_core_tb: FAIL");
		$finish;
	end

	initial begin
		pop = 1'b0;
		forever begin
			@(posedge clk);
			pop <= !(reader_gaps && $urandom_range(0, 99) < 35);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			model.check_triangle({corner_a, corner_b, corner_c, run_last});
	end

	task automatic send_vertex(input logic ls);
		while (sender_gaps && $urandom_range(0, 99) < 35) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push       <= 1'b1;
		list_start <= ls;
		@(posedge clk);
		while (full) @(posedge clk);
		model.note_vertex(ls);
	endtask

	task automatic halt_and_drain();
		push <= 1'b0;
		@(posedge clk);
		while (model.pending_tris.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [KIND_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		model.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [KIND_W-1:0]    dir_kinds[6];
		logic [REG_IDX_W-1:0] idx;
		logic [KIND_W-1:0]    val;
		logic                 ls;
		int                   sent;
		int                   phase;
		int                   phase_len;
		int                   list_left;

		dir_kinds = '{KIND_TRI_LIST, KIND_TRI_STRIP, KIND_TRI_FAN,
			KIND_QUADS, KIND_QUAD_STRIP, KIND_NONE};
		arst_n      = 1'b0;
		push        = 1'b0;
		list_start  = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		sender_gaps = 1'b1;
		reader_gaps = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: one short list per kind, stride stepping from three to twelve.
		for (int k = 0; k < 6; k++) begin
			halt_and_drain();
			write_reg(REG_PRIMITIVE_KIND, dir_kinds[k]);
			write_reg(REG_USE_NORMALS, KIND_W'(k >= 1));
			write_reg(REG_USE_TEXTURES, KIND_W'(k >= 2));
			write_reg(REG_USE_COLORS, KIND_W'(k >= 4));
			send_vertex(1'b1);
			repeat ((dir_kinds[k] == KIND_QUAD_STRIP) ? 4 : 3) send_vertex(1'b0);
		end

		sent      = 0;
		phase     = 0;
		list_left = 0;
		while (sent < RANDOM_ITEMS) begin
			halt_and_drain();
			sender_gaps = (phase % 5 != 2);
			reader_gaps = (phase % 5 != 2);
			repeat ($urandom_range(1, 4)) begin
				idx = REG_IDX_W'($urandom_range(0, 3));
				if (idx == REG_PRIMITIVE_KIND && $urandom_range(0, 9) < 8)
					val = KIND_W'($urandom_range(0, 4));
				else
					val = KIND_W'($urandom_range(0, 7));
				write_reg(idx, val);
			end
			phase_len = $urandom_range(40, 140);
			for (int i = 0; i < phase_len; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					ls = 1'($urandom_range(0, 1));
				end else if (list_left == 0) begin
					ls = 1'b1;
					list_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
						: $urandom_range(1, 14);
				end else begin
					ls = 1'b0;
				end
				if (list_left > 0) list_left--;
				send_vertex(ls);
				sent++;
				if ($urandom_range(0, 199) == 0) halt_and_drain();
			end
			phase++;
		end

		halt_and_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (model.mismatches == 0 && model.pending_tris.size() == 0)
			$display("primitive_index_assembler_core_tb: PASS");
		else
			$display("primitive_index_assembler_core_tb: FAIL");
		$finish;
	end

endmodule
